FILE: hw/rtl/trsc_pkg.sv
// Package for the three-rotor substitution cipher.
// Holds the shared constants, operation codes and the structs that pass
// between the top level and the rotor bank. Depends on nothing.
`default_nettype none

package trsc_pkg;

  localparam int unsigned AlphabetSize = 26;
  localparam int unsigned NumRotors    = 3;

  localparam int unsigned PosW = $clog2(AlphabetSize);
  localparam int unsigned SelW = $clog2(NumRotors);

  localparam logic [PosW-1:0] LastPos   = PosW'(AlphabetSize - 1);
  localparam logic [7:0]      UpperBase = 8'd65;
  localparam logic [7:0]      LowerBase = 8'd97;

  // Operation codes carried on the operation field.
  localparam logic OpTranslate = 1'b0;
  localparam logic OpLoad      = 1'b1;

  // Rotation offsets of the three rotors.
  typedef struct packed {
    logic [PosW-1:0] third;
    logic [PosW-1:0] second;
    logic [PosW-1:0] first;
  } offsets_t;

  // Write request into the rotor tables.
  typedef struct packed {
    logic            en;
    logic [SelW-1:0] sel;
    logic [PosW-1:0] idx;
    logic [PosW-1:0] val;
  } wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/three_rotor_substitution_cipher_top.sv
// Top level of the three-rotor substitution cipher.
// Depends on trsc_pkg and instantiates trsc_rotor_bank.
//
// Usage: one input channel (in_valid_i/in_ready_o) carries load and
// translate items; one output channel (out_valid_o/out_ready_i) carries one
// character per translate item. A load transfer writes one rotor table entry
// and clears all three rotor offsets; a load with a rotor number or position
// out of range is dropped. Loads produce no output transfer.
// Translate items map ASCII letters through rotor 1, 2 and 3, keeping case;
// any other byte is returned unchanged and does not step the rotors.
// Path: an accepted translate is held in the input register, then goes
// through the lookup chain into the result register, which drives the
// output. Throughput: one item per cycle while the receiver keeps up,
// set by the combinational lookup chain of three table reads and
// modulo-26 adds between the two registers.
// The rotor offsets step at the moment a letter is accepted, so back-to-back
// letters each see the correct rotor position.
// When the receiver stalls, the result register holds its character, the
// input register fills, and in_ready_o then drops until the output moves.
// Reset clears the offsets and all valid flags; the rotor tables are
// undefined until loaded.
`default_nettype none

module three_rotor_substitution_cipher_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        operation_i,
  input  wire logic [7:0]                  char_in_i,
  input  wire logic [1:0]                  rotor_select_i,
  input  wire logic [4:0]                  entry_index_i,
  input  wire logic [4:0]                  entry_value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [7:0]                       char_out_o
);

  localparam int unsigned PosW = trsc_pkg::PosW;

  // Input-side decode.
  logic in_fire;
  logic is_upper, is_lower, is_letter;
  logic load_ok;
  logic [PosW-1:0] letter_idx;

  assign in_fire  = in_valid_i && in_ready_o;
  assign is_upper = (char_in_i >= trsc_pkg::UpperBase) &&
                    (char_in_i <  trsc_pkg::UpperBase + 8'(trsc_pkg::AlphabetSize));
  assign is_lower = (char_in_i >= trsc_pkg::LowerBase) &&
                    (char_in_i <  trsc_pkg::LowerBase + 8'(trsc_pkg::AlphabetSize));
  assign is_letter = is_upper || is_lower;
  assign load_ok  = (32'(rotor_select_i) < trsc_pkg::NumRotors) &&
                    (32'(entry_index_i) < trsc_pkg::AlphabetSize);
  assign letter_idx = is_upper ? PosW'(char_in_i - trsc_pkg::UpperBase)
                               : PosW'(char_in_i - trsc_pkg::LowerBase);

  // Rotor offsets: stepped on every accepted letter, cleared by a valid load.
  trsc_pkg::offsets_t offs_q, offs_d;
  logic first_wrap, second_wrap;

  assign first_wrap  = (offs_q.first == trsc_pkg::LastPos);
  assign second_wrap = (offs_q.second == trsc_pkg::LastPos);

  always_comb begin
    offs_d = offs_q;
    if (in_fire) begin
      if (operation_i == trsc_pkg::OpLoad) begin
        if (load_ok) begin
          offs_d = '0;
        end
      end else if (is_letter) begin
        offs_d.first = first_wrap ? '0 : offs_q.first + PosW'(1);
        if (first_wrap) begin
          offs_d.second = second_wrap ? '0 : offs_q.second + PosW'(1);
          if (second_wrap) begin
            offs_d.third = (offs_q.third == trsc_pkg::LastPos) ? '0
                                                               : offs_q.third + PosW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offs_q <= '0;
    end else begin
      offs_q <= offs_d;
    end
  end

  // Table write straight from the accepted load item.
  trsc_pkg::wr_t wr;
  assign wr.en  = in_fire && (operation_i == trsc_pkg::OpLoad) && load_ok;
  assign wr.sel = trsc_pkg::SelW'(rotor_select_i);
  assign wr.idx = PosW'(entry_index_i);
  assign wr.val = PosW'(entry_value_i);

  // Input register: holds a translate item with the offsets it must use.
  logic               s1_valid_q;
  logic               s1_letter_q;
  logic               s1_upper_q;
  logic [7:0]         s1_char_q;
  logic [PosW-1:0]    s1_idx_q;
  trsc_pkg::offsets_t s1_offs_q;
  logic               s1_adv;
  logic               s1_load;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign s1_load    = in_fire && (operation_i == trsc_pkg::OpTranslate);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_letter_q <= is_letter;
      s1_upper_q  <= is_upper;
      s1_char_q   <= char_in_i;
      s1_idx_q    <= letter_idx;
      s1_offs_q   <= offs_q;
    end
  end

  // Lookup chain through the three rotors.
  logic [PosW-1:0] rotor_val;

  trsc_rotor_bank u_bank (
    .clk_i    (clk_i),
    .wr_i     (wr),
    .letter_i (s1_idx_q),
    .offs_i   (s1_offs_q),
    .value_o  (rotor_val)
  );

  logic [7:0] result;
  always_comb begin
    if (!s1_letter_q) begin
      result = s1_char_q;
    end else if (s1_upper_q) begin
      result = trsc_pkg::UpperBase + 8'(rotor_val);
    end else begin
      result = trsc_pkg::LowerBase + 8'(rotor_val);
    end
  end

  // Result register.
  logic       out_valid_q;
  logic [7:0] char_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      char_out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_out_q;

  // A stalled input register keeps its item.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_char_q) && $stable(s1_offs_q))
    else $error("input register lost or changed a stalled item");

  // Offsets never leave the alphabet range.
  a_offs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (offs_q.first <= trsc_pkg::LastPos) && (offs_q.second <= trsc_pkg::LastPos) &&
    (offs_q.third <= trsc_pkg::LastPos))
    else $error("rotor offset out of range");

  // A valid load clears every offset.
  a_load_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |=> offs_q == '0)
    else $error("load did not clear the rotor offsets");

  // Every accepted letter steps the first rotor.
  a_letter_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_load && is_letter |=> offs_q.first != $past(offs_q.first))
    else $error("first rotor did not step on a letter");

endmodule

`default_nettype wire

FILE: hw/rtl/trsc_rotor_bank.sv
// Rotor bank: the three rotor tables and the lookup chain through them.
// Depends on trsc_pkg for widths, constants and the write/offset structs.
`default_nettype none

module trsc_rotor_bank (
  input  wire logic                     clk_i,
  input  wire trsc_pkg::wr_t            wr_i,
  input  wire logic [trsc_pkg::PosW-1:0] letter_i,
  input  wire trsc_pkg::offsets_t       offs_i,
  output logic [trsc_pkg::PosW-1:0]     value_o
);

  localparam int unsigned SumW = trsc_pkg::PosW + 1;

  logic [trsc_pkg::PosW-1:0] rotor_q [trsc_pkg::NumRotors][trsc_pkg::AlphabetSize];

  // Reduces index plus offset (at most 2*AlphabetSize+4) modulo the alphabet.
  function automatic logic [trsc_pkg::PosW-1:0] wrap_pos(
    input logic [trsc_pkg::PosW-1:0] idx,
    input logic [trsc_pkg::PosW-1:0] off
  );
    logic [SumW-1:0] sum;
    sum = SumW'(idx) + SumW'(off);
    if (sum >= SumW'(2 * trsc_pkg::AlphabetSize)) begin
      return trsc_pkg::PosW'(sum - SumW'(2 * trsc_pkg::AlphabetSize));
    end else if (sum >= SumW'(trsc_pkg::AlphabetSize)) begin
      return trsc_pkg::PosW'(sum - SumW'(trsc_pkg::AlphabetSize));
    end
    return trsc_pkg::PosW'(sum);
  endfunction

  // Table entries have no reset; they are undefined until loaded.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rotor_q[wr_i.sel][wr_i.idx] <= wr_i.val;
    end
  end

  logic [trsc_pkg::PosW-1:0] v1, v2;

  always_comb begin
    v1      = rotor_q[0][wrap_pos(letter_i, offs_i.first)];
    v2      = rotor_q[1][wrap_pos(v1, offs_i.second)];
    value_o = rotor_q[2][wrap_pos(v2, offs_i.third)];
  end

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for three_rotor_substitution_cipher_top.
// Holds its own rotor predictor, a queue-fed input driver and an output monitor.
// Depends on trsc_pkg and the cipher RTL only.

module tb_top;

  // One input transfer as it sits on the input ports.
  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic [1:0] sel;
    logic [4:0] idx;
    logic [4:0] val;
  } cipher_item_t;

  localparam int unsigned MaxPrinted = 30;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       operation_i    = trsc_pkg::OpTranslate;
  logic [7:0] char_in_i      = 8'd0;
  logic [1:0] rotor_select_i = 2'd0;
  logic [4:0] entry_index_i  = 5'd0;
  logic [4:0] entry_value_i  = 5'd0;
  logic       out_ready_i    = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] char_out_o;

  three_rotor_substitution_cipher_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .char_in_i     (char_in_i),
    .rotor_select_i(rotor_select_i),
    .entry_index_i (entry_index_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .char_out_o    (char_out_o)
  );

  always #10 clk_i = ~clk_i;

  // Items waiting to be driven, and characters the block still owes us.
  cipher_item_t pending_q[$];
  logic [7:0]   char_expected_q[$];

  // Shadow state of the cipher: the three rotor tables and their offsets.
  logic [4:0]  rotor_map [trsc_pkg::NumRotors][trsc_pkg::AlphabetSize];
  int unsigned first_off, second_off, third_off;

  // Bookkeeping for the summary and the verdict.
  int unsigned error_count    = 0;
  int unsigned letter_count   = 0;
  int unsigned other_count    = 0;
  int unsigned write_count    = 0;
  int unsigned dropped_count  = 0;
  int unsigned third_steps    = 0;
  int unsigned stall_cycles   = 0;

  task automatic report_mismatch(input string msg);
    if (error_count < MaxPrinted) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
    error_count++;
  endtask

  // Advances the predicted cipher by one accepted transfer. A load writes
  // the shadow table and clears the offsets unless its rotor or position is
  // out of range; a translate queues the character the block must return.
  task automatic rotor_predict(input cipher_item_t it);
    int unsigned c;
    int unsigned base;
    int unsigned v;
    c = it.ch;
    if (it.op == trsc_pkg::OpLoad) begin
      if (it.sel < trsc_pkg::NumRotors && it.idx < trsc_pkg::AlphabetSize) begin
        rotor_map[it.sel][it.idx] = it.val;
        first_off  = 0;
        second_off = 0;
        third_off  = 0;
        write_count++;
      end else begin
        dropped_count++;
      end
      return;
    end
    if (c >= trsc_pkg::UpperBase && c < trsc_pkg::UpperBase + trsc_pkg::AlphabetSize) begin
      base = trsc_pkg::UpperBase;
    end else if (c >= trsc_pkg::LowerBase &&
                 c < trsc_pkg::LowerBase + trsc_pkg::AlphabetSize) begin
      base = trsc_pkg::LowerBase;
    end else begin
      // Non-letters come back untouched and leave the rotors where they are.
      char_expected_q.push_back(it.ch);
      other_count++;
      return;
    end
    // Values above 25 coming out of a rotor are folded back by the modulo
    // on the next read; out of the last rotor they simply add to the base.
    v = rotor_map[0][(c - base + first_off) % trsc_pkg::AlphabetSize];
    v = rotor_map[1][(v + second_off) % trsc_pkg::AlphabetSize];
    v = rotor_map[2][(v + third_off) % trsc_pkg::AlphabetSize];
    char_expected_q.push_back(8'(base + v));
    letter_count++;
    first_off = (first_off + 1) % trsc_pkg::AlphabetSize;
    if (first_off == 0) begin
      second_off = (second_off + 1) % trsc_pkg::AlphabetSize;
      if (second_off == 0) begin
        third_off = (third_off + 1) % trsc_pkg::AlphabetSize;
        third_steps++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Input driver. It presents items from pending_q in bursts of random
  // length separated by random gaps. A new item is put on the ports only
  // when the port is free (no valid, or the current one transfers at this
  // edge), so valid and payload never change while a transfer is pending.
  // Every accepted transfer is fed to the predictor in acceptance order,
  // using the values that were on the ports at the edge.
  // ---------------------------------------------------------------------
  int unsigned  burst_left = 0;
  int unsigned  gap_left   = 0;
  cipher_item_t next_item;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      operation_i    <= trsc_pkg::OpTranslate;
      char_in_i      <= 8'd0;
      rotor_select_i <= 2'd0;
      entry_index_i  <= 5'd0;
      entry_value_i  <= 5'd0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rotor_predict({operation_i, char_in_i, rotor_select_i, entry_index_i,
                       entry_value_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 || pending_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid_i <= 1'b0;
        end else begin
          next_item       = pending_q.pop_front();
          in_valid_i     <= 1'b1;
          operation_i    <= next_item.op;
          char_in_i      <= next_item.ch;
          rotor_select_i <= next_item.sel;
          entry_index_i  <= next_item.idx;
          entry_value_i  <= next_item.val;
          if (burst_left <= 1) begin
            // A quarter of the bursts are long and run without any gap.
            if ($urandom_range(0, 3) == 0) begin
              burst_left = $urandom_range(40, 120);
              gap_left   = 0;
            end else begin
              burst_left = $urandom_range(1, 30);
              gap_left   = $urandom_range(0, 8);
            end
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output monitor. Each transfer on the output is compared with the
  // oldest predicted character. The ready pattern switches between modes
  // (always ready, mostly ready, mostly stalled, and a fixed 4-of-7 duty
  // cycle) for random stretches, so stalls land on every phase of the
  // two-stage pipeline, including while the input register is full.
  // ---------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned duty_tick  = 0;
  logic [7:0]  want_char;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_ready_i) stall_cycles++;
      if (out_valid_o && out_ready_i) begin
        if (char_expected_q.size() == 0) begin
          report_mismatch($sformatf("char_out 0x%02h with no character pending",
                                    char_out_o));
        end else begin
          want_char = char_expected_q.pop_front();
          if (char_out_o !== want_char) begin
            report_mismatch($sformatf("char_out 0x%02h, predicted 0x%02h",
                                      char_out_o, want_char));
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(16, 200);
      end else begin
        mode_left--;
      end
      duty_tick = (duty_tick + 1) % 7;
      case (stall_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2: out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (duty_tick < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers. Fields that an operation ignores carry random junk,
  // so every bit of every input field toggles over the run.
  // ---------------------------------------------------------------------
  task automatic push_load(input int unsigned sel, input int unsigned idx,
                           input int unsigned val);
    pending_q.push_back({trsc_pkg::OpLoad, 8'($urandom_range(0, 255)), 2'(sel),
                         5'(idx), 5'(val)});
  endtask

  task automatic push_translate(input logic [7:0] ch);
    pending_q.push_back({trsc_pkg::OpTranslate, ch, 2'($urandom_range(0, 3)),
                         5'($urandom_range(0, 31)), 5'($urandom_range(0, 31))});
  endtask

  // Table values are mostly letter numbers, but a quarter of them are the
  // out-of-range values 26..31 that the datapath must still handle.
  function automatic int unsigned rand_entry_value();
    if ($urandom_range(0, 3) == 0) return $urandom_range(26, 31);
    return $urandom_range(0, 25);
  endfunction

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? trsc_pkg::UpperBase : trsc_pkg::LowerBase;
    return base + 8'($urandom_range(0, trsc_pkg::AlphabetSize - 1));
  endfunction

  // A load that either hits a real table entry or, now and then, is
  // malformed (rotor 3, or a position past the end) and must be dropped.
  task automatic push_random_load();
    case ($urandom_range(0, 15))
      0: push_load(3, $urandom_range(0, 31), $urandom_range(0, 31));
      1: push_load($urandom_range(0, trsc_pkg::NumRotors - 1), $urandom_range(26, 31),
                   $urandom_range(0, 31));
      default: push_load($urandom_range(0, trsc_pkg::NumRotors - 1),
                         $urandom_range(0, trsc_pkg::AlphabetSize - 1),
                         rand_entry_value());
    endcase
  endtask

  // Mostly letters; the rest any byte at all, letters included by chance.
  task automatic push_random_char();
    if ($urandom_range(0, 6) != 0) push_translate(rand_letter());
    else push_translate(8'($urandom_range(0, 255)));
  endtask

  // Holds the sender back until the driver has nothing left and every
  // predicted character has been returned.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || char_expected_q.size() != 0);
  endtask

  // Rounds of a few loads followed by a run of characters, the shape of
  // real use: set up the rotors, then stream text through them.
  task automatic run_mixed_rounds(input int unsigned rounds);
    repeat (rounds) begin
      repeat ($urandom_range(1, 4)) push_random_load();
      repeat ($urandom_range(1, 40)) push_random_char();
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  int unsigned letters_pushed;

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The tables come out of reset undefined, so every entry is loaded
    // before any letter goes through. Nothing resets them afterwards, and
    // later loads only overwrite, so no letter ever reads an unset entry.
    for (int unsigned r = 0; r < trsc_pkg::NumRotors; r++) begin
      for (int unsigned p = 0; p < trsc_pkg::AlphabetSize; p++) begin
        push_load(r, p, rand_entry_value());
      end
    end

    // Directed part: first and last letters of both cases, the bytes just
    // outside each letter range, the byte extremes and high-bit bytes.
    push_translate(trsc_pkg::UpperBase);
    push_translate(trsc_pkg::UpperBase + 8'(trsc_pkg::AlphabetSize - 1));
    push_translate(trsc_pkg::LowerBase);
    push_translate(trsc_pkg::LowerBase + 8'(trsc_pkg::AlphabetSize - 1));
    push_translate(8'h00);
    push_translate(8'hFF);
    push_translate(trsc_pkg::UpperBase - 8'd1);
    push_translate(trsc_pkg::UpperBase + 8'(trsc_pkg::AlphabetSize));
    push_translate(trsc_pkg::LowerBase - 8'd1);
    push_translate(trsc_pkg::LowerBase + 8'(trsc_pkg::AlphabetSize));
    push_translate(8'h80);
    push_translate(8'h80 | trsc_pkg::UpperBase);
    // Extreme table values at both end positions and at position 13, then dropped loads:
    // rotor 3, a position past the end, and both at once.
    push_load(0, trsc_pkg::AlphabetSize - 1, 31);
    push_load(1, 0, 0);
    push_load(2, 13, 26);
    push_load(3, 5, 7);
    push_load(0, 26, 3);
    push_load(2, 31, 31);
    push_load(3, 31, 31);
    push_translate(trsc_pkg::LowerBase + 8'(trsc_pkg::AlphabetSize - 1));
    push_translate(trsc_pkg::UpperBase);
    push_translate(trsc_pkg::UpperBase + 8'd12);
    wait_drained();

    run_mixed_rounds(15);
    wait_drained();

    // One long stretch of text with no loads, long enough for the first
    // rotor to wrap many times, the second to wrap, and the third to step.
    letters_pushed = 0;
    while (letters_pushed < trsc_pkg::AlphabetSize * trsc_pkg::AlphabetSize + 4) begin
      if ($urandom_range(0, 9) == 0) begin
        push_translate(8'($urandom_range(0, trsc_pkg::UpperBase - 1)));
      end else begin
        push_translate(rand_letter());
        letters_pushed++;
      end
    end
    wait_drained();

    run_mixed_rounds(6);
    wait_drained();

    // Let a few cycles pass so a stray extra output would still be seen.
    repeat (10) @(posedge clk_i);

    $display("Checked %0d letters and %0d other bytes,", letter_count, other_count);
    $display("with %0d table writes, %0d dropped loads and %0d third-rotor steps.",
             write_count, dropped_count, third_steps);
    $display("The output stalled for %0d cycles.", stall_cycles);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches in total", error_count);
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Far above the slowest legal run: about 1400 items, each with the
  // longest sender gap and a receiver that is ready only one cycle in four.
  initial begin
    #8_000_000;
    $display("Timeout with %0d items unsent and %0d characters outstanding",
             pending_q.size(), char_expected_q.size());
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/trsc_pkg.sv
hw/rtl/trsc_rotor_bank.sv
hw/rtl/three_rotor_substitution_cipher_top.sv
tb/tb_top.sv
